/* src/hgnm_pkg.sv */
// hgnm_pkg: types and constants shared by the normal map controller,
// datapath and top level. No dependencies.
package hgnm_pkg;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD1,
    OP_RD2,
    OP_RD3,
    OP_DIFF,
    OP_MULX,
    OP_MULY,
    OP_ABS,
    OP_SHIFT,
    OP_SQA,
    OP_SQB,
    OP_SQC,
    OP_SQD,
    OP_SQRT,
    OP_DIVI,
    OP_DIV,
    OP_OUT,
    OP_COMMIT
  } dp_op_t;

  // Which neighbour cell a normal belongs to.
  typedef enum logic [1:0] {
    EMIT_UP,
    EMIT_LEFT,
    EMIT_SELF
  } emit_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_PICK,
    ST_DIFF,
    ST_MULX,
    ST_MULY,
    ST_ABS,
    ST_SHIFT,
    ST_SQA,
    ST_SQB,
    ST_SQC,
    ST_SQD,
    ST_SQRT,
    ST_DIVI,
    ST_DIV,
    ST_OUT,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    emit_t  kind;
    logic   last;
  } cmd_t;

  typedef struct packed {
    logic has_up;
    logic has_left;
    logic has_self;
    logic need_shift;
    logic out_free;
  } status_t;

  localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_NODATA_CODE = 3'd2;
  localparam logic [2:0] CFG_NODATA_FILL = 3'd3;
  localparam logic [2:0] CFG_RELIEF_GAIN = 3'd4;

  localparam logic [10:0] RST_GRID_WIDTH  = 11'd1024;
  localparam logic [12:0] RST_GRID_HEIGHT = 13'd4096;
  localparam logic [23:0] RST_NODATA_CODE = 24'h800000;
  localparam logic [23:0] RST_NODATA_FILL = 24'h000000;
  localparam logic [15:0] RST_RELIEF_GAIN = 16'd1280;

  // 1.0 in slope units: 1000 mm per metre times the Q8.8 gain scale.
  localparam logic [17:0] UNIT_SCALE = 18'd256000;
  localparam logic [63:0] ROOT_ONE_START = 64'h4000_0000_0000_0000;
  localparam logic [4:0]  SQRT_LAST = 5'd31;
  localparam logic [4:0]  DIV_LAST  = 5'd15;
  localparam logic [14:0] Q15_MAX   = 15'h7FFF;

endpackage

/* src/height_grid_normal_map.sv */
// height_grid_normal_map: top level of the surface normal block.
// Depends on hgnm_pkg, hgnm_ctrl and hgnm_dp.
//
// Height samples arrive one item per accepted input, row by row; a sample
// equal to nodata_code is replaced by nodata_fill. Each cell gets the unit
// normal of (-dx, -dy, 1), slopes being central differences times
// relief_gain (one-sided at twice the gain on the edges), given in rounded,
// saturated Q1.15. Normals of row r leave while row r+1 comes in; the last
// row leaves one sample late and its final sample flushes the rest, so an
// item gives zero to three results and last_of_run marks the final one.
// One item is handled at a time. Each normal runs through a 32-step
// bit-serial square root and a 16-step three-lane divider, after right
// shifts while a slope is steep, and waits while the output side stalls.
// Results sit in an output register, so the next item is taken while the
// last result waits. The two line buffers are single-port memories, read
// in RD1 and RD2 and written back in RD3, and need no clearing after
// reset. Writing grid_width or grid_height restarts the frame; the user
// must write configuration only while the block is idle; the block itself
// does not enforce this.
module height_grid_normal_map #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] height_mm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic [14:0]        normal_z,
  output logic [9:0]         cell_col,
  output logic [11:0]        cell_row,
  output logic               last_of_run
);

  hgnm_pkg::cmd_t    cmd;
  hgnm_pkg::status_t st;

  // sequencer: one datapath command per cycle
  hgnm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // line buffers, slope and normalise arithmetic, output register
  hgnm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .height_mm   (height_mm),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .last_of_run (last_of_run)
  );

  // an accepted item closes the input until it is finished
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  // the output register is only loaded when it is free
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == hgnm_pkg::OP_OUT) |-> st.out_free)
    else $error("result overwrote a waiting result");

  // saturation keeps both normal components away from the most negative code
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((normal_x != 16'sh8000) && (normal_y != 16'sh8000)))
    else $error("normal component outside Q1.15 range");

endmodule

/* src/hgnm_ctrl.sv */
// hgnm_ctrl: sequencer for the normal map. Drives one datapath command a
// cycle. Depends on hgnm_pkg.
module hgnm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hgnm_pkg::status_t  st,
  output hgnm_pkg::cmd_t     cmd
);

  hgnm_pkg::ctrl_state_t state, state_next;
  hgnm_pkg::emit_t       kind, kind_next;
  logic                  last, last_next;
  logic                  pend_up, pend_up_next;
  logic                  pend_left, pend_left_next;
  logic                  pend_self, pend_self_next;
  logic [4:0]            cnt, cnt_next;

  assign in_stall = rst || (state != hgnm_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hgnm_pkg::ST_IDLE;
      kind      <= hgnm_pkg::EMIT_UP;
      last      <= 1'b0;
      pend_up   <= 1'b0;
      pend_left <= 1'b0;
      pend_self <= 1'b0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      kind      <= kind_next;
      last      <= last_next;
      pend_up   <= pend_up_next;
      pend_left <= pend_left_next;
      pend_self <= pend_self_next;
      cnt       <= cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    kind_next      = kind;
    last_next      = last;
    pend_up_next   = pend_up;
    pend_left_next = pend_left;
    pend_self_next = pend_self;
    cnt_next       = cnt;
    cmd.op         = hgnm_pkg::OP_NONE;
    cmd.kind       = kind;
    cmd.last       = last;
    case (state)
      hgnm_pkg::ST_IDLE: begin
        if (in_valid && !rst) begin
          cmd.op     = hgnm_pkg::OP_LOAD;
          state_next = hgnm_pkg::ST_RD1;
        end
      end
      hgnm_pkg::ST_RD1: begin
        cmd.op     = hgnm_pkg::OP_RD1;
        state_next = hgnm_pkg::ST_RD2;
      end
      hgnm_pkg::ST_RD2: begin
        cmd.op     = hgnm_pkg::OP_RD2;
        state_next = hgnm_pkg::ST_RD3;
      end
      hgnm_pkg::ST_RD3: begin
        cmd.op         = hgnm_pkg::OP_RD3;
        pend_up_next   = st.has_up;
        pend_left_next = st.has_left;
        pend_self_next = st.has_self;
        state_next     = hgnm_pkg::ST_PICK;
      end
      hgnm_pkg::ST_PICK: begin
        if (pend_up) begin
          kind_next    = hgnm_pkg::EMIT_UP;
          pend_up_next = 1'b0;
          last_next    = !pend_left && !pend_self;
          state_next   = hgnm_pkg::ST_DIFF;
        end else if (pend_left) begin
          kind_next      = hgnm_pkg::EMIT_LEFT;
          pend_left_next = 1'b0;
          last_next      = !pend_self;
          state_next     = hgnm_pkg::ST_DIFF;
        end else if (pend_self) begin
          kind_next      = hgnm_pkg::EMIT_SELF;
          pend_self_next = 1'b0;
          last_next      = 1'b1;
          state_next     = hgnm_pkg::ST_DIFF;
        end else begin
          state_next = hgnm_pkg::ST_COMMIT;
        end
      end
      hgnm_pkg::ST_DIFF: begin
        cmd.op     = hgnm_pkg::OP_DIFF;
        state_next = hgnm_pkg::ST_MULX;
      end
      hgnm_pkg::ST_MULX: begin
        cmd.op     = hgnm_pkg::OP_MULX;
        state_next = hgnm_pkg::ST_MULY;
      end
      hgnm_pkg::ST_MULY: begin
        cmd.op     = hgnm_pkg::OP_MULY;
        state_next = hgnm_pkg::ST_ABS;
      end
      hgnm_pkg::ST_ABS: begin
        cmd.op     = hgnm_pkg::OP_ABS;
        state_next = hgnm_pkg::ST_SHIFT;
      end
      hgnm_pkg::ST_SHIFT: begin
        if (st.need_shift) begin
          cmd.op = hgnm_pkg::OP_SHIFT;
        end else begin
          state_next = hgnm_pkg::ST_SQA;
        end
      end
      hgnm_pkg::ST_SQA: begin
        cmd.op     = hgnm_pkg::OP_SQA;
        state_next = hgnm_pkg::ST_SQB;
      end
      hgnm_pkg::ST_SQB: begin
        cmd.op     = hgnm_pkg::OP_SQB;
        state_next = hgnm_pkg::ST_SQC;
      end
      hgnm_pkg::ST_SQC: begin
        cmd.op     = hgnm_pkg::OP_SQC;
        state_next = hgnm_pkg::ST_SQD;
      end
      hgnm_pkg::ST_SQD: begin
        cmd.op     = hgnm_pkg::OP_SQD;
        cnt_next   = '0;
        state_next = hgnm_pkg::ST_SQRT;
      end
      hgnm_pkg::ST_SQRT: begin
        cmd.op   = hgnm_pkg::OP_SQRT;
        cnt_next = cnt + 5'd1;
        if (cnt == hgnm_pkg::SQRT_LAST) begin
          state_next = hgnm_pkg::ST_DIVI;
        end
      end
      hgnm_pkg::ST_DIVI: begin
        cmd.op     = hgnm_pkg::OP_DIVI;
        cnt_next   = '0;
        state_next = hgnm_pkg::ST_DIV;
      end
      hgnm_pkg::ST_DIV: begin
        cmd.op   = hgnm_pkg::OP_DIV;
        cnt_next = cnt + 5'd1;
        if (cnt == hgnm_pkg::DIV_LAST) begin
          state_next = hgnm_pkg::ST_OUT;
        end
      end
      hgnm_pkg::ST_OUT: begin
        if (st.out_free) begin
          cmd.op     = hgnm_pkg::OP_OUT;
          state_next = hgnm_pkg::ST_PICK;
        end
      end
      hgnm_pkg::ST_COMMIT: begin
        cmd.op     = hgnm_pkg::OP_COMMIT;
        state_next = hgnm_pkg::ST_IDLE;
      end
      default: begin
        state_next = hgnm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/hgnm_dp.sv */
// hgnm_dp: line buffers, counters, config registers, slope and normalise
// arithmetic and the output register. Depends on hgnm_pkg.
module hgnm_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic signed [23:0] height_mm,
  input  hgnm_pkg::cmd_t     cmd,
  output hgnm_pkg::status_t  st,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic [14:0]        normal_z,
  output logic [9:0]         cell_col,
  output logic [11:0]        cell_row,
  output logic               last_of_run
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);

  // config
  logic [10:0] grid_width_q;
  logic [12:0] grid_height_q;
  logic [23:0] nodata_code_q;
  logic [23:0] nodata_fill_q;
  logic [15:0] relief_gain_q;

  // frame position and neighbours
  logic [AW-1:0]      col_cnt, col;
  logic [HW-1:0]      row_cnt, row;
  logic signed [23:0] left_s, left_left_s;
  logic signed [23:0] v, hc, a_next, b_prev, b_same;

  logic signed [23:0] row_one_back [MAX_WIDTH];
  logic signed [23:0] row_two_back [MAX_WIDTH];
  logic signed [23:0] rd_a, rd_b;
  logic [AW-1:0]      addr_a, addr_b;
  logic               mem_re, mem_we;

  logic [31:0]   w32, h32, gw32, gh32;
  logic [AW-1:0] w_m1;
  logic [HW-1:0] h_m1;
  logic          restart_now;
  logic          c_first, c_last, c_one, r_top, r_last;

  // slope
  logic signed [23:0] xp, xm, yp, ym;
  logic               kx_sel, ky_sel, kx, ky;
  logic signed [24:0] dx, dy;
  logic signed [16:0] gain_s;
  logic signed [41:0] prod;
  logic [41:0]        prod_abs;
  logic [40:0]        mag_k;
  logic [40:0]        ax, ay;
  logic [17:0]        cz;
  logic               x_pos, y_pos;

  // sum of squares and root
  logic [30:0] sq_in;
  logic [61:0] sq_p;
  logic [63:0] acc, rad, res, one, root_t;

  // division lanes: x, y, z
  logic [31:0] rr;
  logic [32:0] dvs;
  logic [15:0] low;
  logic [30:0] lane_v   [3];
  logic [33:0] rem      [3];
  logic [33:0] rem_sh   [3];
  logic        rem_ge   [3];
  logic [15:0] quo      [3];

  logic [14:0]   sat_x, sat_y, sat_z;
  logic [AW-1:0] out_c;
  logic [HW-1:0] out_r;

  function automatic logic [14:0] sat15(input logic [15:0] q);
    logic [14:0] r;
    r = (q > 16'(hgnm_pkg::Q15_MAX)) ? hgnm_pkg::Q15_MAX : q[14:0];
    return r;
  endfunction

  assign gw32 = 32'(grid_width_q);
  assign gh32 = 32'(grid_height_q);
  assign w32  = (gw32 < 32'd2) ? 32'd2 :
                ((gw32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : gw32);
  assign h32  = (gh32 < 32'd2) ? 32'd2 :
                ((gh32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : gh32);
  assign w_m1 = AW'(w32 - 32'd1);
  assign h_m1 = HW'(h32 - 32'd1);
  assign restart_now = (32'(col_cnt) >= w32) || (32'(row_cnt) >= h32);

  assign c_first = (col == '0);
  assign c_last  = (col == w_m1);
  assign c_one   = (col == AW'(1));
  assign r_top   = (row == HW'(1));
  assign r_last  = (row == h_m1);

  assign st.has_up     = (row != '0);
  assign st.has_left   = r_last && !c_first;
  assign st.has_self   = r_last && c_last;
  assign st.need_shift = (ax[40:31] != '0) || (ay[40:31] != '0);
  assign st.out_free   = !out_valid || !out_stall;

  // config and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width_q  <= hgnm_pkg::RST_GRID_WIDTH;
      grid_height_q <= hgnm_pkg::RST_GRID_HEIGHT;
      nodata_code_q <= hgnm_pkg::RST_NODATA_CODE;
      nodata_fill_q <= hgnm_pkg::RST_NODATA_FILL;
      relief_gain_q <= hgnm_pkg::RST_RELIEF_GAIN;
      col_cnt       <= '0;
      row_cnt       <= '0;
      left_s        <= '0;
      left_left_s   <= '0;
    end else begin
      if (cmd.op == hgnm_pkg::OP_LOAD && restart_now) begin
        col_cnt     <= '0;
        row_cnt     <= '0;
        left_s      <= '0;
        left_left_s <= '0;
      end
      if (cmd.op == hgnm_pkg::OP_COMMIT) begin
        left_left_s <= left_s;
        left_s      <= v;
        if (c_last) begin
          col_cnt <= '0;
          row_cnt <= r_last ? '0 : row + HW'(1);
        end else begin
          col_cnt <= col + AW'(1);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          hgnm_pkg::CFG_GRID_WIDTH: begin
            grid_width_q <= cfg_data[10:0];
            col_cnt      <= '0;
            row_cnt      <= '0;
            left_s       <= '0;
            left_left_s  <= '0;
          end
          hgnm_pkg::CFG_GRID_HEIGHT: begin
            grid_height_q <= cfg_data[12:0];
            col_cnt       <= '0;
            row_cnt       <= '0;
            left_s        <= '0;
            left_left_s   <= '0;
          end
          hgnm_pkg::CFG_NODATA_CODE: nodata_code_q <= cfg_data;
          hgnm_pkg::CFG_NODATA_FILL: nodata_fill_q <= cfg_data;
          hgnm_pkg::CFG_RELIEF_GAIN: relief_gain_q <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // line buffers: reads in RD1/RD2, write-back in RD3
  assign mem_re = (cmd.op == hgnm_pkg::OP_RD1) || (cmd.op == hgnm_pkg::OP_RD2);
  assign mem_we = (cmd.op == hgnm_pkg::OP_RD3);

  always_comb begin
    if (cmd.op == hgnm_pkg::OP_RD2) begin
      if (c_first) begin
        addr_a = AW'(1);
      end else if (c_last) begin
        addr_a = col;
      end else begin
        addr_a = col + AW'(1);
      end
      addr_b = col;
    end else begin
      addr_a = col;
      addr_b = c_first ? '0 : col - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_one_back[col] <= v;
      row_two_back[col] <= hc;
    end
    if (mem_re) begin
      rd_a <= row_one_back[addr_a];
      rd_b <= row_two_back[addr_b];
    end
  end

  // operand selection per cell kind
  always_comb begin
    xp     = v;
    xm     = left_s;
    kx_sel = 1'b1;
    yp     = v;
    ym     = hc;
    ky_sel = 1'b1;
    case (cmd.kind)
      hgnm_pkg::EMIT_UP: begin
        if (c_last) begin
          xp = hc;     xm = b_prev; kx_sel = 1'b1;
        end else if (c_first) begin
          xp = a_next; xm = hc;     kx_sel = 1'b1;
        end else begin
          xp = a_next; xm = b_prev; kx_sel = 1'b0;
        end
        if (r_top) begin
          yp = v; ym = hc;     ky_sel = 1'b1;
        end else begin
          yp = v; ym = b_same; ky_sel = 1'b0;
        end
      end
      hgnm_pkg::EMIT_LEFT: begin
        if (c_one) begin
          xp = v; xm = left_s;      kx_sel = 1'b1;
        end else begin
          xp = v; xm = left_left_s; kx_sel = 1'b0;
        end
        yp = left_s; ym = b_prev; ky_sel = 1'b1;
      end
      hgnm_pkg::EMIT_SELF: begin
        xp = v; xm = left_s; kx_sel = 1'b1;
        yp = v; ym = hc;     ky_sel = 1'b1;
      end
      default: ;
    endcase
  end

  assign gain_s   = $signed({1'b0, relief_gain_q});
  assign prod_abs = prod[41] ? 42'(-prod) : 42'(prod);

  always_comb begin
    if ((cmd.op == hgnm_pkg::OP_MULY) ? kx : ky) begin
      mag_k = {prod_abs[39:0], 1'b0};
    end else begin
      mag_k = prod_abs[40:0];
    end
  end

  always_comb begin
    case (cmd.op)
      hgnm_pkg::OP_SQA: sq_in = ax[30:0];
      hgnm_pkg::OP_SQB: sq_in = ay[30:0];
      default:          sq_in = 31'(cz);
    endcase
  end

  assign root_t = res + one;
  assign rr     = (res[31:0] == '0) ? 32'd1 : res[31:0];

  assign lane_v[0] = ax[30:0];
  assign lane_v[1] = ay[30:0];
  assign lane_v[2] = 31'(cz);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem[i][32:0], low[15]};
      rem_ge[i] = (rem_sh[i] >= 34'(dvs));
    end
  end

  assign sat_x = sat15(quo[0]);
  assign sat_y = sat15(quo[1]);
  assign sat_z = sat15(quo[2]);

  always_comb begin
    case (cmd.kind)
      hgnm_pkg::EMIT_UP: begin
        out_c = col;
        out_r = row - HW'(1);
      end
      hgnm_pkg::EMIT_LEFT: begin
        out_c = col - AW'(1);
        out_r = row;
      end
      default: begin
        out_c = col;
        out_r = row;
      end
    endcase
  end

  // arithmetic pipeline registers, no reset
  always_ff @(posedge clk) begin
    case (cmd.op)
      hgnm_pkg::OP_LOAD: begin
        v   <= (height_mm == nodata_code_q) ? $signed(nodata_fill_q) : height_mm;
        col <= restart_now ? '0 : col_cnt;
        row <= restart_now ? '0 : row_cnt;
      end
      hgnm_pkg::OP_RD2: begin
        hc     <= rd_a;
        b_prev <= rd_b;
      end
      hgnm_pkg::OP_RD3: begin
        a_next <= rd_a;
        b_same <= rd_b;
      end
      hgnm_pkg::OP_DIFF: begin
        dx <= 25'(xp) - 25'(xm);
        dy <= 25'(yp) - 25'(ym);
        kx <= kx_sel;
        ky <= ky_sel;
      end
      hgnm_pkg::OP_MULX: begin
        prod <= 42'(dx) * 42'(gain_s);
      end
      hgnm_pkg::OP_MULY: begin
        prod  <= 42'(dy) * 42'(gain_s);
        ax    <= mag_k;
        x_pos <= !prod[41] && (prod != '0);
      end
      hgnm_pkg::OP_ABS: begin
        ay    <= mag_k;
        y_pos <= !prod[41] && (prod != '0);
        cz    <= hgnm_pkg::UNIT_SCALE;
      end
      hgnm_pkg::OP_SHIFT: begin
        ax <= ax >> 1;
        ay <= ay >> 1;
        cz <= cz >> 1;
      end
      hgnm_pkg::OP_SQA: begin
        sq_p <= sq_in * sq_in;
      end
      hgnm_pkg::OP_SQB: begin
        sq_p <= sq_in * sq_in;
        acc  <= 64'(sq_p);
      end
      hgnm_pkg::OP_SQC: begin
        sq_p <= sq_in * sq_in;
        acc  <= acc + 64'(sq_p);
      end
      hgnm_pkg::OP_SQD: begin
        rad <= acc + 64'(sq_p);
        res <= '0;
        one <= hgnm_pkg::ROOT_ONE_START;
      end
      hgnm_pkg::OP_SQRT: begin
        if (rad >= root_t) begin
          rad <= rad - root_t;
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
      end
      hgnm_pkg::OP_DIVI: begin
        // (v*65536 + R) / 2R: upper part seeds the remainder
        dvs <= {rr, 1'b0};
        low <= rr[15:0];
        for (int i = 0; i < 3; i++) begin
          rem[i] <= 34'(lane_v[i]) + 34'(rr[31:16]);
          quo[i] <= '0;
        end
      end
      hgnm_pkg::OP_DIV: begin
        low <= {low[14:0], 1'b0};
        for (int i = 0; i < 3; i++) begin
          if (rem_ge[i]) begin
            rem[i] <= rem_sh[i] - 34'(dvs);
            quo[i] <= {quo[i][14:0], 1'b1};
          end else begin
            rem[i] <= rem_sh[i];
            quo[i] <= {quo[i][14:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == hgnm_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == hgnm_pkg::OP_OUT) begin
      normal_x    <= x_pos ? -$signed({1'b0, sat_x}) : $signed({1'b0, sat_x});
      normal_y    <= y_pos ? -$signed({1'b0, sat_y}) : $signed({1'b0, sat_y});
      normal_z    <= sat_z;
      cell_col    <= 10'(out_c);
      cell_row    <= 12'(out_r);
      last_of_run <= cmd.last;
    end
  end

endmodule
